@@ src/power_of_two_block_allocator_macros.svh @@
`ifndef POWER_OF_TWO_BLOCK_ALLOCATOR_MACROS_SVH
`define POWER_OF_TWO_BLOCK_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define P2BA_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("p2ba check failed");

// consequent checked in the cycle after the antecedent
`define P2BA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("p2ba check failed");

`endif

@@ src/p2ba_pkg.sv @@
`timescale 1ns / 1ps

package p2ba_pkg;

   localparam int ADDR_BITS   = 20;
   localparam int UNIT_BYTES  = 8;
   localparam int UNIT_LOG    = $clog2(UNIT_BYTES + 1) - 1;
   localparam int CLASS_COUNT = ADDR_BITS + 1;
   localparam int LINK_W      = ADDR_BITS + 1;
   localparam int IDX_W       = $clog2(CLASS_COUNT);
   localparam int BYTES_W     = 24;
   localparam int CLASS_W     = 5;
   localparam int CHUNK_W     = 5;
   localparam int LIMIT_W     = 21;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef logic [1:0]             kind_type;
   typedef logic [BYTES_W-1:0]     bytes_type;
   typedef logic [ADDR_BITS-1:0]   addr_type;
   typedef logic [CLASS_W-1:0]     class_type;
   typedef logic [1:0]             status_type;
   typedef logic [LINK_W-1:0]      link_type;
   typedef logic [LINK_W-1:0]      fill_type;
   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [CHUNK_W-1:0]     chunk_type;
   typedef logic [LIMIT_W-1:0]     limit_type;
   typedef logic                   csr_index_type;
   typedef logic [LIMIT_W-1:0]     csr_data_type;
   typedef logic [1:0]             cmd_op_type;
   typedef logic [QPTR_W-1:0]      qptr_type;
   typedef logic [QCOUNT_W-1:0]    qcount_type;

   localparam kind_type KIND_ALLOC = 2'd0;
   localparam kind_type KIND_FREE  = 2'd1;
   localparam kind_type KIND_GROW  = 2'd2;

   localparam status_type ST_DONE    = 2'd0;
   localparam status_type ST_OOM     = 2'd1;
   localparam status_type ST_IGNORED = 2'd2;

   localparam cmd_op_type CMD_REPORT = 2'd0;
   localparam cmd_op_type CMD_ALLOC  = 2'd1;
   localparam cmd_op_type CMD_FREE   = 2'd2;

   localparam csr_index_type CSR_CHUNK_BITS = 1'b0;
   localparam csr_index_type CSR_POOL_LIMIT = 1'b1;

   localparam link_type  NULL_LINK        = link_type'(1) << ADDR_BITS;
   localparam chunk_type CHUNK_BITS_RESET = chunk_type'(16);
   localparam limit_type POOL_LIMIT_RESET = limit_type'(1048576);

   // classified request handed from the front end to the engine
   typedef struct packed {
      cmd_op_type op;
      status_type status;
      class_type  size_class;
      class_type  alloc_class;
      class_type  push_class;
      addr_type   addr;
      logic       old_push;
   } cmd_type;

endpackage

@@ src/p2ba_ifs.sv @@
`timescale 1ns / 1ps

interface p2ba_req_if;
   import p2ba_pkg::*;

   logic      valid;
   logic      ready;
   kind_type  kind;
   bytes_type size_bytes;
   bytes_type old_size_bytes;
   addr_type  block_address;
   logic      address_null;

   modport source (output valid, kind, size_bytes, old_size_bytes, block_address,
                   address_null, input ready);
   modport sink (input valid, kind, size_bytes, old_size_bytes, block_address,
                 address_null, output ready);
endinterface

interface p2ba_rsp_if;
   import p2ba_pkg::*;

   logic       valid;
   logic       ready;
   addr_type   result_address;
   class_type  size_class;
   status_type status;

   modport source (output valid, result_address, size_class, status, input ready);
   modport sink (input valid, result_address, size_class, status, output ready);
endinterface

@@ src/p2ba_ram.sv @@
`timescale 1ns / 1ps

module p2ba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/p2ba_front.sv @@
`timescale 1ns / 1ps

module p2ba_front (
   p2ba_req_if.sink             req_if,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output p2ba_pkg::cmd_type    cmd
);
   import p2ba_pkg::*;

   // 0 up to one unit, else bit length of n-1 less the unit exponent
   function automatic class_type class_of(bytes_type n);
      bytes_type m;
      int        bl;
      m  = n - bytes_type'(1);
      bl = 0;
      for (int k = 0; k < BYTES_W; k++) begin
         if (m[k]) begin
            bl = k + 1;
         end
      end
      if (n <= bytes_type'(UNIT_BYTES)) begin
         return '0;
      end
      return class_type'(bl - UNIT_LOG);
   endfunction

   class_type size_cls;
   class_type old_cls;
   logic      size_ok;
   logic      old_ok;

   assign size_cls  = class_of(req_if.size_bytes);
   assign old_cls   = class_of(req_if.old_size_bytes);
   assign size_ok   = int'(size_cls) <= ADDR_BITS;
   assign old_ok    = int'(old_cls) <= ADDR_BITS;
   assign cmd_valid = req_if.valid;
   assign req_if.ready = cmd_ready;

   always_comb begin
      cmd.op          = CMD_REPORT;
      cmd.status      = ST_IGNORED;
      cmd.size_class  = size_cls;
      cmd.alloc_class = size_cls;
      cmd.push_class  = size_cls;
      cmd.addr        = req_if.block_address;
      cmd.old_push    = 1'b0;
      case (req_if.kind)
         KIND_ALLOC, KIND_GROW: begin
            if (req_if.size_bytes == '0) begin
               cmd.status = ST_IGNORED;
            end else if (!size_ok) begin
               cmd.status = ST_OOM;
            end else begin
               cmd.op = CMD_ALLOC;
               if (req_if.kind == KIND_GROW) begin
                  cmd.push_class = old_cls;
                  cmd.old_push   = (req_if.old_size_bytes != '0) && !req_if.address_null
                                   && old_ok;
               end
            end
         end
         KIND_FREE: begin
            if (!req_if.address_null && (req_if.size_bytes != '0) && size_ok) begin
               cmd.op = CMD_FREE;
            end
         end
         default: begin
            cmd.size_class = '0;
         end
      endcase
   end

endmodule

@@ src/p2ba_queue.sv @@
`timescale 1ns / 1ps

module p2ba_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  p2ba_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output p2ba_pkg::cmd_type pop_cmd
);
   import p2ba_pkg::*;

   cmd_type    slot_ff [QUEUE_DEPTH];
   qptr_type   wr_ptr_ff, wr_ptr_in;
   qptr_type   rd_ptr_ff, rd_ptr_in;
   qcount_type count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = count_ff < qcount_type'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == qptr_type'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == qptr_type'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/p2ba_back.sv @@
`timescale 1ns / 1ps

module p2ba_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_pop,
   input  p2ba_pkg::cmd_type   cmd,
   input  p2ba_pkg::chunk_type chunk_bits,
   input  p2ba_pkg::limit_type pool_limit,
   p2ba_rsp_if.source          rsp_if
);
   import p2ba_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_POP      = 4'd2;
   localparam logic [3:0] S_UNLINK   = 4'd3;
   localparam logic [3:0] S_FRESH    = 4'd4;
   localparam logic [3:0] S_SPLIT    = 4'd5;
   localparam logic [3:0] S_LOW      = 4'd6;
   localparam logic [3:0] S_OLD      = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   localparam int SUM_W = ((LIMIT_W > LINK_W) ? LIMIT_W : LINK_W) + 1;
   typedef logic [SUM_W-1:0] sum_type;

   logic [3:0] state_ff, state_in;
   logic [3:0] after_alloc;
   cmd_type    cmd_ff, cmd_in;
   addr_type   base_ff, base_in;
   addr_type   res_ff, res_in;
   class_type  step_ff, step_in;
   status_type status_ff, status_in;
   fill_type   pool_fill_ff, pool_fill_in;

   link_type   head_ff [CLASS_COUNT];
   logic       head_we;
   idx_type    head_widx;
   idx_type    head_ridx;
   link_type   head_wdata;
   link_type   head_rdata;

   logic       ram_we;
   addr_type   ram_waddr;
   addr_type   ram_raddr;
   link_type   ram_wdata;
   link_type   ram_rdata;

   logic       rsp_valid_ff, rsp_valid_in;
   addr_type   rsp_addr_ff, rsp_addr_in;
   class_type  rsp_class_ff, rsp_class_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       out_free;

   logic [CLASS_COUNT-1:0] nonempty;
   logic [CLASS_COUNT-1:0] above;
   logic       found;
   idx_type    found_idx;
   logic       own_ready;

   class_type  fresh_exp;
   sum_type    fresh_sum;
   sum_type    fresh_lim;
   logic       fresh_fail;
   addr_type   split_addr;

   p2ba_ram #(
      .WIDTH (LINK_W),
      .DEPTH (1 << ADDR_BITS)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // empty lists hold the null marker in their top bit
   always_comb begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
         nonempty[c] = !head_ff[c][ADDR_BITS];
         above[c]    = class_type'(c) > cmd_ff.alloc_class;
      end
   end

   // smallest larger class with a free block
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
         if (nonempty[c] && above[c]) begin
            found     = 1'b1;
            found_idx = idx_type'(c);
         end
      end
   end

   assign own_ready = nonempty[idx_type'(cmd_ff.alloc_class)];

   always_comb begin
      head_ridx = '0;
      case (state_ff)
         S_DISPATCH: begin
            if (cmd_ff.op == CMD_FREE) begin
               head_ridx = idx_type'(cmd_ff.push_class);
            end else if (cmd_ff.op == CMD_ALLOC) begin
               head_ridx = own_ready ? idx_type'(cmd_ff.alloc_class) : found_idx;
            end
         end
         S_OLD: begin
            head_ridx = idx_type'(cmd_ff.push_class);
         end
         default: begin
            head_ridx = '0;
         end
      endcase
   end

   assign head_rdata = head_ff[head_ridx];

   assign fresh_exp  = (cmd_ff.alloc_class >= chunk_bits) ? cmd_ff.alloc_class : chunk_bits;
   assign fresh_sum  = sum_type'(pool_fill_ff) + (sum_type'(1) << fresh_exp);
   assign fresh_lim  = (sum_type'(pool_limit) < sum_type'(NULL_LINK)) ? sum_type'(pool_limit)
                                                                      : sum_type'(NULL_LINK);
   assign fresh_fail = (int'(fresh_exp) > ADDR_BITS) || (fresh_sum > fresh_lim);
   assign split_addr = base_ff + (addr_type'(1) << step_ff);

   assign after_alloc = cmd_ff.old_push ? S_OLD : S_DONE;
   assign out_free    = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      base_in       = base_ff;
      res_in        = res_ff;
      step_in       = step_ff;
      status_in     = status_ff;
      pool_fill_in  = pool_fill_ff;
      head_we       = 1'b0;
      head_widx     = idx_type'(cmd_ff.alloc_class);
      head_wdata    = ram_rdata;
      ram_we        = 1'b0;
      ram_waddr     = base_ff;
      ram_wdata     = NULL_LINK;
      ram_raddr     = head_rdata[ADDR_BITS-1:0];
      cmd_pop       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_in    = '0;
            status_in = cmd_ff.status;
            case (cmd_ff.op)
               CMD_FREE: begin
                  ram_we     = 1'b1;
                  ram_waddr  = cmd_ff.addr;
                  ram_wdata  = head_rdata;
                  head_we    = 1'b1;
                  head_widx  = idx_type'(cmd_ff.push_class);
                  head_wdata = {1'b0, cmd_ff.addr};
                  status_in  = ST_DONE;
                  state_in   = S_DONE;
               end
               CMD_ALLOC: begin
                  status_in = ST_DONE;
                  if (own_ready) begin
                     res_in   = head_rdata[ADDR_BITS-1:0];
                     state_in = S_POP;
                  end else if (found) begin
                     base_in  = head_rdata[ADDR_BITS-1:0];
                     step_in  = class_type'(found_idx);
                     state_in = S_UNLINK;
                  end else begin
                     state_in = S_FRESH;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_POP: begin
            head_we  = 1'b1;
            state_in = after_alloc;
         end
         S_UNLINK: begin
            // the larger block leaves its list before it is carved up
            head_we   = 1'b1;
            head_widx = idx_type'(step_ff);
            step_in   = step_ff - 1'b1;
            state_in  = S_SPLIT;
         end
         S_FRESH: begin
            if (fresh_fail) begin
               status_in = ST_OOM;
               state_in  = S_DONE;
            end else begin
               base_in      = pool_fill_ff[ADDR_BITS-1:0];
               pool_fill_in = fill_type'(fresh_sum);
               if (fresh_exp == cmd_ff.alloc_class) begin
                  ram_we    = 1'b1;
                  ram_waddr = pool_fill_ff[ADDR_BITS-1:0];
                  res_in    = pool_fill_ff[ADDR_BITS-1:0];
                  state_in  = after_alloc;
               end else begin
                  step_in  = fresh_exp - 1'b1;
                  state_in = S_SPLIT;
               end
            end
         end
         S_SPLIT: begin
            ram_we    = 1'b1;
            ram_waddr = split_addr;
            head_we   = 1'b1;
            if (step_ff > cmd_ff.alloc_class) begin
               // upper half of each intermediate class becomes a lone free block
               head_widx  = idx_type'(step_ff);
               head_wdata = {1'b0, split_addr};
               step_in    = step_ff - 1'b1;
            end else begin
               ram_wdata  = {1'b0, base_ff};
               head_wdata = {1'b0, base_ff};
               res_in     = split_addr;
               state_in   = S_LOW;
            end
         end
         S_LOW: begin
            ram_we   = 1'b1;
            state_in = after_alloc;
         end
         S_OLD: begin
            ram_we     = 1'b1;
            ram_waddr  = cmd_ff.addr;
            ram_wdata  = head_rdata;
            head_we    = 1'b1;
            head_widx  = idx_type'(cmd_ff.push_class);
            head_wdata = {1'b0, cmd_ff.addr};
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_ff;
               rsp_class_in  = cmd_ff.size_class;
               rsp_status_in = status_ff;
               if (cmd_valid) begin
                  cmd_pop  = 1'b1;
                  cmd_in   = cmd;
                  state_in = S_DISPATCH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pool_fill_ff <= '0;
         for (int c = 0; c < CLASS_COUNT; c++) begin
            head_ff[c] <= NULL_LINK;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pool_fill_ff <= pool_fill_in;
         if (head_we) begin
            head_ff[head_widx] <= head_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      base_ff       <= base_in;
      res_ff        <= res_in;
      step_ff       <= step_in;
      status_ff     <= status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.result_address = rsp_addr_ff;
   assign rsp_if.size_class     = rsp_class_ff;
   assign rsp_if.status         = rsp_status_ff;

endmodule

@@ src/power_of_two_block_allocator.sv @@
// channel   dir  handshake      word
// req_if    in   valid/ready    kind, size_bytes, old_size_bytes, block_address, address_null
// rsp_if    out  valid/ready    result_address, size_class, status
// csr_*     in   csr_we         csr_index selects chunk_bits or pool_limit, csr_wdata
//
// steps per word in the engine sequencer, whose link memory has a read and a write port:
//   free: dispatch, done; pop: dispatch, pop, done; unsplit fresh: dispatch, fresh, done;
//   split: dispatch, unlink or fresh, split per class, low, done; grow's old block: old
// reset clears the list heads to empty and the pool fill to zero; the link memory needs
// no clearing pass
// a two-entry queue lets the front take words while the engine works or the
// result register waits on rsp_if.ready
`timescale 1ns / 1ps
`include "power_of_two_block_allocator_macros.svh"

module power_of_two_block_allocator (
   input  logic                    clock,
   input  logic                    reset,
   p2ba_req_if.sink                req_if,
   p2ba_rsp_if.source              rsp_if,
   input  logic                    csr_we,
   input  p2ba_pkg::csr_index_type csr_index,
   input  p2ba_pkg::csr_data_type  csr_wdata
);
   import p2ba_pkg::*;

   chunk_type chunk_bits_ff, chunk_bits_in;
   limit_type pool_limit_ff, pool_limit_in;

   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   always_comb begin
      chunk_bits_in = chunk_bits_ff;
      pool_limit_in = pool_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHUNK_BITS: chunk_bits_in = csr_wdata[CHUNK_W-1:0];
            CSR_POOL_LIMIT: pool_limit_in = csr_wdata[LIMIT_W-1:0];
            default: begin
               chunk_bits_in = chunk_bits_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_bits_ff <= CHUNK_BITS_RESET;
         pool_limit_ff <= POOL_LIMIT_RESET;
      end else begin
         chunk_bits_ff <= chunk_bits_in;
         pool_limit_ff <= pool_limit_in;
      end
   end

   p2ba_front u_front (
      .req_if    (req_if),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   p2ba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_cmd    (q_cmd)
   );

   p2ba_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_pop    (q_pop),
      .cmd        (q_cmd),
      .chunk_bits (chunk_bits_ff),
      .pool_limit (pool_limit_ff),
      .rsp_if     (rsp_if)
   );

   // a refused or failed request never hands out an address
   `P2BA_ASSERT_SAME(a_refusal_no_addr, clock, reset, rsp_if.valid && (rsp_if.status != ST_DONE), rsp_if.result_address == '0)
   // an accepted word is waiting for the engine on the next cycle
   `P2BA_ASSERT_NEXT(a_accept_queued, clock, reset, req_if.valid && req_if.ready, q_valid)
   // the engine only takes a command that the queue offers
   `P2BA_ASSERT_SAME(a_pop_has_cmd, clock, reset, q_pop, q_valid)

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import p2ba_pkg::*;

   localparam int       STALL_LIMIT  = 2000;
   localparam int       TAIL_CYCLES  = 60;
   localparam int       LIVE_MAX     = 40;
   localparam kind_type KIND_UNKNOWN = 2'd3;

   typedef struct {
      kind_type  kind;
      bytes_type size_bytes;
      bytes_type old_size_bytes;
      addr_type  block_address;
      logic      address_null;
   } request_type;

   typedef struct {
      addr_type   address;
      class_type  size_class;
      status_type status;
   } response_type;

   typedef struct {
      addr_type  address;
      bytes_type size_bytes;
   } live_block_type;

   // free-list allocator state mirrored word by word, plus the results still owed
   class block_pool_model;
      chunk_type    chunk_bits;
      limit_type    pool_limit;
      link_type     heads[CLASS_COUNT];
      link_type     links[addr_type];
      longint       pool_fill;
      response_type expected_q[$];
      int           failures;

      function new();
         chunk_bits = CHUNK_BITS_RESET;
         pool_limit = POOL_LIMIT_RESET;
         foreach (heads[i]) heads[i] = NULL_LINK;
         pool_fill = 0;
         failures  = 0;
      endfunction

      function void write_reg(csr_index_type idx, csr_data_type data);
         if (idx == CSR_CHUNK_BITS)
            chunk_bits = data[CHUNK_W-1:0];
         else
            pool_limit = data;
      endfunction

      function int class_of(bytes_type n);
         int        bits;
         bytes_type v;
         if (n <= UNIT_BYTES)
            return 0;
         v    = n - bytes_type'(1);
         bits = 0;
         for (int i = 0; i < BYTES_W; i++)
            if (v[i]) bits = i + 1;
         return bits - UNIT_LOG;
      endfunction

      function link_type link_at(addr_type a);
         if (links.exists(a))
            return links[a];
         return NULL_LINK;
      endfunction

      // leaves one free block per class b..top-1 and a second class-b block at base
      function void split_block(addr_type base, int b, int top);
         addr_type a;
         for (int i = b; i < top; i++) begin
            a = addr_type'(longint'(base) + (longint'(1) << i));
            heads[i] = {1'b0, a};
            links[a] = NULL_LINK;
         end
         a = addr_type'(longint'(base) + (longint'(1) << b));
         links[a]    = {1'b0, base};
         links[base] = NULL_LINK;
      endfunction

      function status_type alloc_block(int b, output addr_type a);
         int       e;
         longint   lim;
         longint   sz;
         addr_type base;
         bit       found;
         a = '0;
         if (b > ADDR_BITS)
            return ST_OOM;
         if (heads[b] == NULL_LINK) begin
            found = 1'b0;
            for (int j = b + 1; j < CLASS_COUNT && !found; j++) begin
               if (heads[j] != NULL_LINK) begin
                  base     = addr_type'(heads[j]);
                  heads[j] = link_at(base);
                  split_block(base, b, j);
                  found = 1'b1;
               end
            end
            if (!found) begin
               e   = (b >= int'(chunk_bits)) ? b : int'(chunk_bits);
               lim = (longint'(pool_limit) < longint'(NULL_LINK)) ?
                     longint'(pool_limit) : longint'(NULL_LINK);
               if (e > ADDR_BITS)
                  return ST_OOM;
               sz = longint'(1) << e;
               if (pool_fill + sz > lim)
                  return ST_OOM;
               base      = addr_type'(pool_fill);
               pool_fill = pool_fill + sz;
               if (e == b) begin
                  heads[b]    = {1'b0, base};
                  links[base] = NULL_LINK;
               end else begin
                  split_block(base, b, e);
               end
            end
         end
         a        = addr_type'(heads[b]);
         heads[b] = link_at(a);
         return ST_DONE;
      endfunction

      function status_type free_block(addr_type a, bytes_type n, logic is_null);
         int c;
         if (is_null || n == 0)
            return ST_IGNORED;
         c = class_of(n);
         if (c > ADDR_BITS)
            return ST_IGNORED;
         links[a] = heads[c];
         heads[c] = {1'b0, a};
         return ST_DONE;
      endfunction

      function response_type note_request(request_type w);
         response_type r;
         int           cls;
         status_type   st;
         addr_type     a;
         a   = '0;
         cls = (w.size_bytes == 0) ? 0 : class_of(w.size_bytes);
         case (w.kind)
            KIND_ALLOC, KIND_GROW: begin
               if (w.size_bytes == 0) begin
                  st = ST_IGNORED;
               end else begin
                  st = alloc_block(cls, a);
                  // a failed grow keeps its old block
                  if (st == ST_DONE && w.kind == KIND_GROW && w.old_size_bytes != 0)
                     void'(free_block(w.block_address, w.old_size_bytes, w.address_null));
               end
            end
            KIND_FREE: st = free_block(w.block_address, w.size_bytes, w.address_null);
            default: begin
               cls = 0;
               st  = ST_IGNORED;
            end
         endcase
         r.address    = a;
         r.size_class = class_type'(cls);
         r.status     = st;
         expected_q.push_back(r);
         return r;
      endfunction

      function void check_response(addr_type a, class_type c, status_type s);
         response_type exp;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result word: addr %h class %0d status %0d", a, c, s);
            return;
         end
         exp = expected_q.pop_front();
         if (exp.address !== a || exp.size_class !== c || exp.status !== s) begin
            failures++;
            if (failures <= 10)
               $display("result mismatch: expected addr %h class %0d status %0d, got %h %0d %0d",
                        exp.address, exp.size_class, exp.status, a, c, s);
         end
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         csr_we;
   csr_index_type csr_index;
   csr_data_type csr_wdata;
   bit           req_throttle;
   bit           rsp_throttle;
   int           idle_cycles;

   block_pool_model pool_model;
   live_block_type  live_blocks[$];

   p2ba_req_if req_bus ();
   p2ba_rsp_if rsp_bus ();

   power_of_two_block_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic bytes_type random_bytes();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return bytes_type'($urandom_range(1, 256));
      if (r < 90)
         return bytes_type'($urandom_range(257, 8192));
      if (r < 98)
         return bytes_type'($urandom_range(8193, 131072));
      return bytes_type'($urandom_range(1, 8388608));
   endfunction

   task automatic send_request(request_type w, output response_type pred);
      int gap;
      gap = pick_gap(req_throttle);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.kind           <= w.kind;
      req_bus.size_bytes     <= w.size_bytes;
      req_bus.old_size_bytes <= w.old_size_bytes;
      req_bus.block_address  <= w.block_address;
      req_bus.address_null   <= w.address_null;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pred = pool_model.note_request(w);
      if ((w.kind == KIND_ALLOC || w.kind == KIND_GROW) && pred.status == ST_DONE)
         live_blocks.push_back('{pred.address, w.size_bytes});
   endtask

   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      while (pool_model.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, csr_data_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      pool_model.write_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      response_type r;
      send_request('{KIND_ALLOC, 24'd0, 24'd0, 20'd0, 1'b0}, r);
      send_request('{KIND_ALLOC, 24'd1, 24'd0, 20'd0, 1'b0}, r);
      send_request('{KIND_ALLOC, 24'd8, 24'd0, 20'd0, 1'b0}, r);
      send_request('{KIND_ALLOC, 24'd9, 24'd0, 20'd0, 1'b0}, r);
      // class above the address width
      send_request('{KIND_ALLOC, 24'hFFFFFF, 24'd0, 20'd0, 1'b0}, r);
      // largest class, pool too full for it
      send_request('{KIND_ALLOC, 24'd8388608, 24'd0, 20'd0, 1'b0}, r);
      send_request('{KIND_FREE, 24'd8, 24'd0, 20'd1, 1'b1}, r);
      send_request('{KIND_FREE, 24'd0, 24'd0, 20'd1, 1'b0}, r);
      send_request('{KIND_FREE, 24'hFFFFFF, 24'd0, 20'd1, 1'b0}, r);
      send_request('{KIND_UNKNOWN, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 1'b1}, r);
      send_request('{KIND_FREE, 24'd8, 24'd0, 20'd1, 1'b0}, r);
      send_request('{KIND_GROW, 24'd100, 24'd8, 20'd0, 1'b0}, r);
      send_request('{KIND_GROW, 24'd24, 24'd0, 20'd3, 1'b0}, r);
      send_request('{KIND_GROW, 24'd16, 24'd16, 20'd2, 1'b1}, r);
      send_request('{KIND_GROW, 24'd0, 24'd8, 20'd1, 1'b0}, r);
      // failed grow must not release the old word's block
      send_request('{KIND_GROW, 24'hFFFFFF, 24'd8, 20'd1, 1'b0}, r);
      send_request('{KIND_GROW, 24'd64, 24'hF00000, 20'd5, 1'b0}, r);
      send_request('{KIND_FREE, 24'd8, 24'd0, 20'hFFFFF, 1'b0}, r);
      send_request('{KIND_ALLOC, 24'd8, 24'd0, 20'd0, 1'b0}, r);
      send_request('{KIND_FREE, 24'd8388608, 24'd0, 20'd0, 1'b0}, r);
      // deep split of the class 20 block
      send_request('{KIND_ALLOC, 24'd1048576, 24'd0, 20'd0, 1'b0}, r);
      send_request('{KIND_ALLOC, 24'd8, 24'd0, 20'd0, 1'b0}, r);
      send_request('{KIND_ALLOC, 24'd8388608, 24'd0, 20'd0, 1'b0}, r);
   endtask

   task automatic run_random(int count);
      request_type    w;
      response_type   r;
      live_block_type old;
      int             pick;
      int             sel;
      bit             had_old;
      for (int n = 0; n < count; n++) begin
         w       = '{KIND_ALLOC, 24'd0, 24'd0, 20'd0, 1'b0};
         had_old = 1'b0;
         pick    = $urandom_range(0, 99);
         if (live_blocks.size() > LIVE_MAX && pick < 45)
            pick = 50;
         if (pick < 45) begin
            w.size_bytes = random_bytes();
         end else if (pick < 88 && live_blocks.size() != 0) begin
            sel = $urandom_range(0, live_blocks.size() - 1);
            old = live_blocks[sel];
            live_blocks.delete(sel);
            had_old         = 1'b1;
            w.block_address = old.address;
            if (pick < 75) begin
               w.kind       = KIND_FREE;
               w.size_bytes = old.size_bytes;
            end else begin
               w.kind           = KIND_GROW;
               w.size_bytes     = random_bytes();
               w.old_size_bytes = old.size_bytes;
            end
         end else begin
            w.kind           = kind_type'($urandom_range(0, 3));
            w.size_bytes     = $urandom_range(0, 1) ? random_bytes() : bytes_type'($urandom);
            w.old_size_bytes = $urandom_range(0, 1) ? random_bytes() : bytes_type'($urandom);
            w.block_address  = addr_type'($urandom);
            w.address_null   = $urandom_range(0, 3) == 0;
         end
         send_request(w, r);
         if (had_old && w.kind == KIND_GROW && r.status != ST_DONE)
            live_blocks.push_back(old);
         if ($urandom_range(0, 99) == 0)
            wait_results_drained();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         pool_model.check_response(rsp_bus.result_address, rsp_bus.size_class, rsp_bus.status);
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         int gap;
         gap = pick_gap(rsp_throttle);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // nothing moving on any port for too long means a hang
   always @(posedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("power_of_two_block_allocator verification failed");
         $finish;
      end
   end

   initial begin
      pool_model             = new();
      req_throttle           = 1'b1;
      rsp_throttle           = 1'b1;
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_CHUNK_BITS;
      csr_wdata              <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.kind           <= KIND_ALLOC;
      req_bus.size_bytes     <= '0;
      req_bus.old_size_bytes <= '0;
      req_bus.block_address  <= '0;
      req_bus.address_null   <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(300);

      // single fresh blocks of exactly the requested class, widest limit
      wait_results_drained();
      write_csr(CSR_CHUNK_BITS, csr_data_type'(0));
      write_csr(CSR_POOL_LIMIT, csr_data_type'(21'h1FFFFF));
      req_throttle = $urandom_range(0, 3) != 0;
      rsp_throttle = $urandom_range(0, 3) != 0;
      run_random(260);

      // chunk exponent out of range: only the free lists can serve
      wait_results_drained();
      write_csr(CSR_CHUNK_BITS, {16'($urandom), 5'd31});
      req_throttle = 1'b1;
      rsp_throttle = 1'b1;
      run_random(260);

      // pool limit of zero, no idling on either side
      wait_results_drained();
      write_csr(CSR_CHUNK_BITS, csr_data_type'(20));
      write_csr(CSR_POOL_LIMIT, csr_data_type'(0));
      req_throttle = 1'b0;
      rsp_throttle = 1'b0;
      run_random(260);

      wait_results_drained();
      write_csr(CSR_CHUNK_BITS, csr_data_type'(3));
      write_csr(CSR_POOL_LIMIT, csr_data_type'(POOL_LIMIT_RESET));
      req_throttle = 1'b1;
      rsp_throttle = 1'b1;
      run_random(260);

      wait_results_drained();
      write_csr(CSR_CHUNK_BITS, csr_data_type'(9));
      write_csr(CSR_POOL_LIMIT, csr_data_type'($urandom_range(1 << 19, 1 << 20)));
      req_throttle = $urandom_range(0, 1) != 0;
      rsp_throttle = 1'b1;
      run_random(260);

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pool_model.failures == 0 && pool_model.outstanding() == 0)
         $display("power_of_two_block_allocator verification clean");
      else
         $display("power_of_two_block_allocator verification failed");
      $finish;
   end

endmodule
